// File: rtl/sorted_triple_degree_counter_unit_assert.svh
// Assertion macros for the top module, which checks itself.
`ifndef SORTED_TRIPLE_DEGREE_COUNTER_UNIT_ASSERT_SVH
`define SORTED_TRIPLE_DEGREE_COUNTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STDC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/stdc_pkg.sv
`timescale 1ns / 1ps

package stdc_pkg;

  typedef enum logic [1:0] {
    KIND_TOTAL   = 2'd0,
    KIND_PARTIAL = 2'd1,
    KIND_LABEL   = 2'd2
  } degree_kind_e;

  // Which result groups one accepted beat produces.
  typedef struct packed {
    logic grp;    // finished first-ID group: total, partial, labeled
    logic part;   // finished second-ID run: partial only
    logic flush;  // end of stream: total, partial, labeled of the open group
  } job_ctl_t;

  localparam int unsigned JOB_CTL_W  = $bits(job_ctl_t);
  localparam int unsigned JOB_VALS   = 6;
  localparam int unsigned VAL_IDX_W  = 3;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned ID_PORT_W  = 32;
  localparam int unsigned VAL_PORT_W = 32;

  // Value slots inside a job.
  localparam logic [VAL_IDX_W-1:0] SLOT_OLD_PARTIAL = 3'd1;
  localparam logic [VAL_IDX_W-1:0] SLOT_FLUSH_BASE  = 3'd3;

  function automatic degree_kind_e kind_of(input logic [1:0] pos);
    degree_kind_e k;
    unique case (pos)
      2'd0:    k = KIND_TOTAL;
      2'd1:    k = KIND_PARTIAL;
      default: k = KIND_LABEL;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/stdc_front.sv
`timescale 1ns / 1ps

module stdc_front #(
  parameter int unsigned ID_WIDTH    = 32,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            s_axis_tvalid,
  output logic                                            s_axis_tready,
  input  logic [3*stdc_pkg::ID_PORT_W-1:0]                s_axis_tdata,
  input  logic                                            s_axis_tlast,
  input  logic                                            q_full_i,
  output logic                                            push_o,
  output stdc_pkg::job_ctl_t                              ctl_o,
  output logic [stdc_pkg::JOB_VALS-1:0][COUNT_WIDTH-1:0]  vals_o
);

  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (&v) ? v : v + CountOne;
  endfunction

  logic [ID_WIDTH-1:0]    id_a, id_b, id_c;
  logic [ID_WIDTH-1:0]    prev_a_q, prev_a_d, prev_b_q, prev_b_d, prev_c_q, prev_c_d;
  logic                   have_q, have_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d, partial_q, partial_d, label_q, label_d;
  logic [COUNT_WIDTH-1:0] t_mid, p_mid, l_mid;
  logic                   accept, grp, part;

  assign id_a = ID_WIDTH'(s_axis_tdata[stdc_pkg::ID_PORT_W-1:0]);
  assign id_b = ID_WIDTH'(s_axis_tdata[2*stdc_pkg::ID_PORT_W-1:stdc_pkg::ID_PORT_W]);
  assign id_c = ID_WIDTH'(s_axis_tdata[3*stdc_pkg::ID_PORT_W-1:2*stdc_pkg::ID_PORT_W]);

  assign s_axis_tready = !q_full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    t_mid = total_q;
    p_mid = partial_q;
    l_mid = label_q;
    grp   = 1'b0;
    part  = 1'b0;
    priority if (!have_q) begin
      t_mid = CountOne;
      p_mid = CountOne;
      l_mid = CountOne;
    end else if (id_a == prev_a_q && id_b == prev_b_q && id_c == prev_c_q) begin
      // Repeated triple: counts stay.
    end else if (id_a != prev_a_q) begin
      grp   = 1'b1;
      t_mid = CountOne;
      p_mid = CountOne;
      l_mid = CountOne;
    end else begin
      t_mid = sat_inc(total_q);
      if (id_b != prev_b_q) begin
        part  = 1'b1;
        l_mid = sat_inc(label_q);
        p_mid = CountOne;
      end else begin
        p_mid = sat_inc(partial_q);
      end
    end

    ctl_o.grp   = grp;
    ctl_o.part  = part;
    ctl_o.flush = s_axis_tlast;
    vals_o[0] = total_q;
    vals_o[1] = partial_q;
    vals_o[2] = label_q;
    vals_o[3] = t_mid;
    vals_o[4] = p_mid;
    vals_o[5] = l_mid;
    push_o = accept && (grp || part || s_axis_tlast);

    prev_a_d  = prev_a_q;
    prev_b_d  = prev_b_q;
    prev_c_d  = prev_c_q;
    have_d    = have_q;
    total_d   = total_q;
    partial_d = partial_q;
    label_d   = label_q;
    if (accept) begin
      prev_a_d = id_a;
      prev_b_d = id_b;
      prev_c_d = id_c;
      if (s_axis_tlast) begin
        have_d    = 1'b0;
        total_d   = CountOne;
        partial_d = CountOne;
        label_d   = CountOne;
      end else begin
        have_d    = 1'b1;
        total_d   = t_mid;
        partial_d = p_mid;
        label_d   = l_mid;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q  <= '0;
      prev_b_q  <= '0;
      prev_c_q  <= '0;
      have_q    <= 1'b0;
      total_q   <= CountOne;
      partial_q <= CountOne;
      label_q   <= CountOne;
    end else begin
      prev_a_q  <= prev_a_d;
      prev_b_q  <= prev_b_d;
      prev_c_q  <= prev_c_d;
      have_q    <= have_d;
      total_q   <= total_d;
      partial_q <= partial_d;
      label_q   <= label_d;
    end
  end

endmodule

// File: rtl/stdc_queue.sv
`timescale 1ns / 1ps

module stdc_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             valid_o,
  output logic [WIDTH-1:0] rdata_o
);

  // Two entries: enough for the front to keep going while the back drains a job.
  logic [WIDTH-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/stdc_back.sv
`timescale 1ns / 1ps

module stdc_back #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            head_valid_i,
  input  stdc_pkg::job_ctl_t                              head_ctl_i,
  input  logic [stdc_pkg::JOB_VALS-1:0][COUNT_WIDTH-1:0]  head_vals_i,
  output logic                                            pop_o,
  output logic                                            m_axis_tvalid,
  input  logic                                            m_axis_tready,
  output logic [stdc_pkg::VAL_PORT_W-1:0]                 m_axis_tdata,
  output logic [1:0]                                      m_axis_tuser,
  output logic                                            m_axis_tlast
);

  logic [stdc_pkg::STEP_W-1:0]    step_q, step_d, n_res, lead, rel;
  logic [stdc_pkg::VAL_IDX_W-1:0] idx;
  stdc_pkg::degree_kind_e         kind;
  logic                           is_last, load;
  logic                           valid_q, last_q;
  logic [stdc_pkg::VAL_PORT_W-1:0] data_q;
  stdc_pkg::degree_kind_e         kind_q;

  assign load = head_valid_i && (!valid_q || m_axis_tready);

  always_comb begin
    // Results of the closed run come first, then the end-of-stream flush.
    lead  = head_ctl_i.grp ? 3'd3 : (head_ctl_i.part ? 3'd1 : 3'd0);
    n_res = lead + (head_ctl_i.flush ? 3'd3 : 3'd0);
    rel   = step_q - lead;
    if (step_q < lead) begin
      idx  = head_ctl_i.grp ? step_q : stdc_pkg::SLOT_OLD_PARTIAL;
      kind = head_ctl_i.grp ? stdc_pkg::kind_of(step_q[1:0]) : stdc_pkg::KIND_PARTIAL;
    end else begin
      idx  = stdc_pkg::SLOT_FLUSH_BASE + rel;
      kind = stdc_pkg::kind_of(rel[1:0]);
    end
    is_last = step_q == n_res - 3'd1;
    pop_o   = load && is_last;
    step_d  = step_q;
    if (load) begin
      step_d = is_last ? '0 : step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= stdc_pkg::VAL_PORT_W'(head_vals_i[idx]);
      kind_q <= kind;
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= '0;
    end else begin
      step_q <= step_d;
      if (load) begin
        valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

endmodule

// File: rtl/sorted_triple_degree_counter_unit.sv
// A result beat passes the job queue and the back end's output register. Throughput: one
// input beat per cycle unless the job queue is full; the output side moves one result beat
// per cycle while m_axis_tready is high, so an input beat with k results gives k beats in a
// row, and the two-entry job queue between front and back sets how far input runs ahead.
// Reset: asynchronous, active low; clears history, counters to one, queue empty.
`timescale 1ns / 1ps
`include "sorted_triple_degree_counter_unit_assert.svh"

module sorted_triple_degree_counter_unit #(
  parameter int unsigned ID_WIDTH    = 32,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata: first_id [31:0], second_id [63:32], third_id [95:64]
  input  logic [3*stdc_pkg::ID_PORT_W-1:0]    s_axis_tdata,
  // tlast: end_of_stream
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata: degree_value [31:0]
  output logic [stdc_pkg::VAL_PORT_W-1:0]     m_axis_tdata,
  // tuser: degree_kind [1:0]
  output logic [1:0]                          m_axis_tuser,
  // tlast: last_of_run
  output logic                                m_axis_tlast
);

  localparam int unsigned JobW = stdc_pkg::JOB_CTL_W + stdc_pkg::JOB_VALS * COUNT_WIDTH;

  logic                                            q_full, q_valid, q_push, q_pop;
  stdc_pkg::job_ctl_t                              f_ctl, h_ctl;
  logic [stdc_pkg::JOB_VALS-1:0][COUNT_WIDTH-1:0]  f_vals, h_vals;
  logic [JobW-1:0]                                 q_wdata, q_rdata;

  stdc_front #(
    .ID_WIDTH   (ID_WIDTH),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .q_full_i     (q_full),
    .push_o       (q_push),
    .ctl_o        (f_ctl),
    .vals_o       (f_vals)
  );

  assign q_wdata         = {f_vals, f_ctl};
  assign {h_vals, h_ctl} = q_rdata;

  stdc_queue #(
    .WIDTH(JobW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(q_wdata),
    .pop_i  (q_pop),
    .full_o (q_full),
    .valid_o(q_valid),
    .rdata_o(q_rdata)
  );

  stdc_back #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (q_valid),
    .head_ctl_i   (h_ctl),
    .head_vals_i  (h_vals),
    .pop_o        (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  `STDC_ASSERT_SAME(a_no_push_full, q_push, !q_full, "job pushed into a full queue")
  `STDC_ASSERT_SAME(a_job_has_result, q_push, f_ctl.grp || f_ctl.part || f_ctl.flush, "empty job queued")
  `STDC_ASSERT_SAME(a_pop_has_job, q_pop, q_valid, "pop from an empty queue")
  `STDC_ASSERT_NEXT(a_run_continues, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid, "result run broken")

endmodule

// File: tb/sv/sorted_triple_degree_counter_unit_test.sv
`timescale 1ns / 1ps

module sorted_triple_degree_counter_unit_test;

  localparam int unsigned RANDOM_TRIPLES = 410;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned DRAIN_CYCLES   = 32;
  localparam logic [31:0] ID_MAX         = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [stdc_pkg::ID_PORT_W-1:0] first_id;
    logic [stdc_pkg::ID_PORT_W-1:0] second_id;
    logic [stdc_pkg::ID_PORT_W-1:0] third_id;
    logic                           end_of_stream;
  } triple_t;

  typedef struct packed {
    stdc_pkg::degree_kind_e          kind;
    logic [stdc_pkg::VAL_PORT_W-1:0] value;
    logic                            last;
  } degree_beat_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               s_axis_tvalid = 1'b0;
  logic                               s_axis_tready;
  logic [3*stdc_pkg::ID_PORT_W-1:0]   s_axis_tdata = '0;
  logic                               s_axis_tlast = 1'b0;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready = 1'b0;
  logic [stdc_pkg::VAL_PORT_W-1:0]    m_axis_tdata;
  logic [1:0]                         m_axis_tuser;
  logic                               m_axis_tlast;

  sorted_triple_degree_counter_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  triple_t      triples_to_send[$];
  degree_beat_t degrees_due[$];
  int unsigned  errors = 0;
  int unsigned  stall_cycles = 0;

  // Shadow copy of the counter state, advanced on every accepted input beat.
  logic [31:0] seen_first, seen_second, seen_third;
  logic        group_open;
  logic [31:0] total_deg, partial_deg, label_deg;

  function automatic logic [31:0] bump(input logic [31:0] v);
    return (v == ID_MAX) ? v : v + 32'd1;
  endfunction

  task automatic close_group();
    degrees_due.push_back('{stdc_pkg::KIND_TOTAL, total_deg, 1'b0});
    degrees_due.push_back('{stdc_pkg::KIND_PARTIAL, partial_deg, 1'b0});
    degrees_due.push_back('{stdc_pkg::KIND_LABEL, label_deg, 1'b0});
    total_deg   = 32'd1;
    partial_deg = 32'd1;
    label_deg   = 32'd1;
  endtask

  task automatic count_triple(input triple_t t);
    int unsigned queued_before;
    queued_before = degrees_due.size();
    if (!group_open) begin
      total_deg   = 32'd1;
      partial_deg = 32'd1;
      label_deg   = 32'd1;
      group_open  = 1'b1;
    end else if (t.first_id == seen_first && t.second_id == seen_second &&
                 t.third_id == seen_third) begin
      // A repeated triple adds nothing.
    end else if (t.first_id != seen_first) begin
      close_group();
    end else begin
      total_deg = bump(total_deg);
      if (t.second_id != seen_second) begin
        label_deg = bump(label_deg);
        degrees_due.push_back('{stdc_pkg::KIND_PARTIAL, partial_deg, 1'b0});
        partial_deg = 32'd1;
      end else begin
        partial_deg = bump(partial_deg);
      end
    end
    seen_first  = t.first_id;
    seen_second = t.second_id;
    seen_third  = t.third_id;
    if (t.end_of_stream) begin
      close_group();
      group_open = 1'b0;
    end
    if (degrees_due.size() > queued_before) begin
      degrees_due[degrees_due.size()-1].last = 1'b1;
    end
  endtask

  // Sender side.
  triple_t     next_triple;
  int unsigned send_gap = 0;
  bit          send_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      send_gap      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap      <= send_gap - 1;
      end else if (triples_to_send.size() != 0) begin
        next_triple = triples_to_send.pop_front();
        s_axis_tdata  <= {next_triple.third_id, next_triple.second_id, next_triple.first_id};
        s_axis_tlast  <= next_triple.end_of_stream;
        s_axis_tvalid <= 1'b1;
        if ($urandom_range(0, 15) == 0) send_calm = !send_calm;
        send_gap <= send_calm ? 0 : $urandom_range(0, 12);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver side: after each result beat, ready drops for a randomly drawn gap, which may be zero.
  int unsigned recv_gap = 0;
  int unsigned recv_draw;
  bit          recv_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if ($urandom_range(0, 15) == 0) recv_calm = !recv_calm;
      recv_draw = recv_calm ? 0 : $urandom_range(0, 12);
      recv_gap      <= recv_draw;
      m_axis_tready <= (recv_draw == 0);
    end else if (recv_gap != 0) begin
      recv_gap      <= recv_gap - 1;
      m_axis_tready <= (recv_gap == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: input beats feed the predictor before output beats are checked.
  triple_t      took_triple;
  degree_beat_t want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        took_triple = '{s_axis_tdata[stdc_pkg::ID_PORT_W-1:0],
                        s_axis_tdata[2*stdc_pkg::ID_PORT_W-1:stdc_pkg::ID_PORT_W],
                        s_axis_tdata[3*stdc_pkg::ID_PORT_W-1:2*stdc_pkg::ID_PORT_W],
                        s_axis_tlast};
        count_triple(took_triple);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (degrees_due.size() == 0) begin
          $error("unexpected result beat: degree_kind %0d degree_value %0d last_of_run %0b",
                 m_axis_tuser, m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          want = degrees_due.pop_front();
          if (m_axis_tuser !== want.kind) begin
            $error("degree_kind: expected %0d, actual %0d", want.kind, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata !== want.value) begin
            $error("degree_value: expected %0d, actual %0d", want.value, m_axis_tdata);
            errors++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, m_axis_tlast);
            errors++;
          end
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  task automatic add_triple(input logic [31:0] a, input logic [31:0] b,
                            input logic [31:0] c, input logic eos);
    triples_to_send.push_back('{a, b, c, eos});
  endtask

  initial begin
    logic [31:0] grp_first, run_second, leaf_third;
    int unsigned groups, runs, leaves, target;
    bit          timed_out;

    timed_out  = 1'b0;
    seen_first = '0;
    seen_second = '0;
    seen_third = '0;
    group_open = 1'b0;
    total_deg  = 32'd1;
    partial_deg = 32'd1;
    label_deg  = 32'd1;

    // Directed: a lone first triple that also ends the stream, then a repeat, changes of
    // the third, second and first ID, and a repeat carrying the end mark.
    add_triple('0, '0, '0, 1'b1);
    add_triple('0, '0, '0, 1'b0);
    add_triple('0, '0, '0, 1'b0);
    add_triple('0, '0, 32'd1, 1'b0);
    add_triple('0, ID_MAX, ID_MAX, 1'b0);
    add_triple(ID_MAX, ID_MAX, ID_MAX, 1'b0);
    add_triple(ID_MAX, ID_MAX, ID_MAX, 1'b1);
    add_triple(ID_MAX, '0, '0, 1'b0);
    add_triple(ID_MAX, 32'd1, 32'd5, 1'b0);
    add_triple(ID_MAX, 32'd1, 32'd6, 1'b0);
    // First ID changes on the end mark: six results from one beat.
    add_triple(32'd1, '0, '0, 1'b1);
    // Keys that go backwards are still treated as changes.
    add_triple(32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    add_triple(32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    add_triple(32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    add_triple(32'h7FFF_FFFF, 32'h0000_0001, 32'h5555_5555, 1'b1);
    add_triple(32'h7FFF_FFFF, 32'h0000_0001, 32'h5555_5555, 1'b0);
    add_triple(32'h7FFF_FFFF, 32'h0000_0001, 32'h5555_5554, 1'b0);

    // Random: mostly sorted streams with random keys, some noise beats.
    target = triples_to_send.size() + RANDOM_TRIPLES;
    while (triples_to_send.size() < target) begin
      if ($urandom_range(0, 6) == 0) begin
        add_triple($urandom(), $urandom(), $urandom(), $urandom_range(0, 3) == 0);
      end else begin
        grp_first = $urandom();
        groups    = $urandom_range(1, 4);
        for (int unsigned g = 0; g < groups; g++) begin
          run_second = $urandom();
          runs       = $urandom_range(1, 4);
          for (int unsigned r = 0; r < runs; r++) begin
            leaf_third = $urandom();
            leaves     = $urandom_range(1, 3);
            for (int unsigned l = 0; l < leaves; l++) begin
              add_triple(grp_first, run_second, leaf_third, 1'b0);
              if ($urandom_range(0, 5) == 0) add_triple(grp_first, run_second, leaf_third, 1'b0);
              leaf_third += $urandom_range(1, 50);
            end
            run_second += $urandom_range(1, 1000);
          end
          grp_first += $urandom_range(1, 1 << 20);
        end
        // Most streams end with the mark; the others run into the next stream.
        if ($urandom_range(0, 4) != 0) begin
          triples_to_send[triples_to_send.size()-1].end_of_stream = 1'b1;
        end
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!timed_out &&
           (triples_to_send.size() != 0 || s_axis_tvalid || degrees_due.size() != 0)) begin
      @(negedge clk_i);
      if (stall_cycles >= STALL_LIMIT) timed_out = 1'b1;
    end
    if (!timed_out) repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (!timed_out && errors == 0 && degrees_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/stdc_pkg.sv
rtl/stdc_front.sv
rtl/stdc_queue.sv
rtl/stdc_back.sv
rtl/sorted_triple_degree_counter_unit.sv
tb/sv/sorted_triple_degree_counter_unit_test.sv
